FILE: hw/rtl/clocked_serial_frame_exchange_core_macros.svh
// ----------------------------------------------------------------------------
// clocked_serial_frame_exchange_core_macros.svh
// Assertion helpers for the serial frame exchange core.
// ----------------------------------------------------------------------------
`ifndef CLOCKED_SERIAL_FRAME_EXCHANGE_CORE_MACROS_SVH
`define CLOCKED_SERIAL_FRAME_EXCHANGE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CSFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CSFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/csfe_pkg.sv
// ----------------------------------------------------------------------------
// csfe_pkg
// Shared types and constants of the serial frame exchange core.
// ----------------------------------------------------------------------------
`default_nettype none

package csfe_pkg;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned FRAME_BYTES   = 4;
	localparam int unsigned FRAME_BITS    = BITS_PER_BYTE * FRAME_BYTES;

	// phase codes
	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_WAIT_HIGH = 2'd1;
	localparam logic [1:0] PH_WAIT_LOW  = 2'd2;
	localparam logic [1:0] PH_RETRY     = 2'd3;

	// command codes
	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_RECEIVE = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_SEND    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_TIMEOUT     = 2'd0;
	localparam logic [1:0] CFG_RETRY_DELAY = 2'd1;
	localparam logic [1:0] CFG_READ_CODE   = 2'd2;

	localparam logic [15:0] TIMEOUT_RESET     = 16'h2000;
	localparam logic [15:0] RETRY_DELAY_RESET = 16'd1000;
	localparam logic [7:0]  READ_CODE_RESET   = 8'h00;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  code_in;
		logic [7:0]  extra_in;
		logic [15:0] value_in;
		logic        serial_clock;
		logic        serial_data_in;
	} item_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [15:0] retry_delay_ticks;
		logic [7:0]  read_param_code;
	} cfg_t;

	typedef struct packed {
		logic        serial_data_out;
		logic        select_out;
		logic        request_out;
		logic        busy_res;
		logic        done_res;
		logic [7:0]  code_out;
		logic [7:0]  extra_out;
		logic [15:0] value_out;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/csfe_engine.sv
// ----------------------------------------------------------------------------
// csfe_engine
// Frame state machine: one tick per step, result formed from the new state.
// ----------------------------------------------------------------------------
`default_nettype none

module csfe_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire csfe_pkg::item_t item,
	input  wire csfe_pkg::cfg_t  cfg,
	output csfe_pkg::res_t       res
);

	logic [1:0]  phase_q,  phase_d;
	logic [2:0]  bit_q,    bit_d;
	logic [1:0]  byte_q,   byte_d;
	logic [31:0] tx_q,     tx_d;
	logic [31:0] rx_q,     rx_d;
	logic [15:0] wait_q,   wait_d;
	logic [15:0] retry_q,  retry_d;
	logic        dout_q,   dout_d;

	logic        done;
	logic [4:0]  rot_n;
	logic [31:0] rot_word;
	logic        wait_out;
	logic        framing;

	// undo the rotation done so far so a retry resends the original frame
	assign rot_n    = {byte_q, bit_q};
	assign rot_word = (tx_q >> rot_n) | (tx_q << (6'd32 - {1'b0, rot_n}));
	assign wait_out = (wait_q <= 16'd1);

	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		byte_d  = byte_q;
		tx_d    = tx_q;
		rx_d    = rx_q;
		wait_d  = wait_q;
		retry_d = retry_q;
		dout_d  = dout_q;
		done    = 1'b0;

		case (phase_q)
			csfe_pkg::PH_WAIT_HIGH, csfe_pkg::PH_WAIT_LOW: begin
				if (phase_q == csfe_pkg::PH_WAIT_HIGH && item.serial_clock) begin
					dout_d  = tx_q[31];
					tx_d    = {tx_q[30:0], tx_q[31]};
					rx_d    = {rx_q[30:0], item.serial_data_in};
					bit_d   = bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						byte_d = byte_q + 2'd1;
					end
					wait_d  = cfg.timeout_ticks;
					phase_d = csfe_pkg::PH_WAIT_LOW;
				end else if (phase_q == csfe_pkg::PH_WAIT_LOW && !item.serial_clock) begin
					if (bit_q == 3'd0 && byte_q == 2'd0) begin
						done    = 1'b1;
						phase_d = csfe_pkg::PH_IDLE;
					end else begin
						wait_d  = cfg.timeout_ticks;
						phase_d = csfe_pkg::PH_WAIT_HIGH;
					end
				end else if (wait_out) begin
					wait_d  = 16'd0;
					tx_d    = rot_word;
					retry_d = cfg.retry_delay_ticks;
					phase_d = csfe_pkg::PH_RETRY;
				end else begin
					wait_d = wait_q - 16'd1;
				end
			end
			csfe_pkg::PH_RETRY: begin
				if (retry_q == 16'd0) begin
					bit_d   = 3'd0;
					byte_d  = 2'd0;
					rx_d    = 32'd0;
					wait_d  = cfg.timeout_ticks;
					phase_d = csfe_pkg::PH_WAIT_HIGH;
				end else begin
					retry_d = retry_q - 16'd1;
				end
			end
			default: begin
				if (item.command != csfe_pkg::CMD_NONE) begin
					case (item.command)
						csfe_pkg::CMD_RECEIVE: tx_d = 32'd0;
						csfe_pkg::CMD_READ:
							tx_d = {cfg.read_param_code, item.extra_in, 16'd0};
						default:
							tx_d = {item.code_in, item.extra_in, item.value_in};
					endcase
					bit_d   = 3'd0;
					byte_d  = 2'd0;
					rx_d    = 32'd0;
					wait_d  = cfg.timeout_ticks;
					phase_d = csfe_pkg::PH_WAIT_HIGH;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= csfe_pkg::PH_IDLE;
			bit_q   <= 3'd0;
			byte_q  <= 2'd0;
			tx_q    <= 32'd0;
			rx_q    <= 32'd0;
			wait_q  <= 16'd0;
			retry_q <= 16'd0;
			dout_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			tx_q    <= tx_d;
			rx_q    <= rx_d;
			wait_q  <= wait_d;
			retry_q <= retry_d;
			dout_q  <= dout_d;
		end
	end

	assign framing = (phase_d == csfe_pkg::PH_WAIT_HIGH) ||
	                 (phase_d == csfe_pkg::PH_WAIT_LOW);

	always_comb begin
		res.serial_data_out = dout_d;
		res.select_out      = framing;
		res.request_out     = framing;
		res.busy_res        = (phase_d != csfe_pkg::PH_IDLE);
		res.done_res        = done;
		res.code_out        = done ? rx_q[31:24] : 8'd0;
		res.extra_out       = done ? rx_q[23:16] : 8'd0;
		res.value_out       = done ? rx_q[15:0]  : 16'd0;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/clocked_serial_frame_exchange_core.sv
// Output: a result is registered and leaves in the cycle after its tick is accepted.
// Throughput: one tick per cycle; input stalls only while the output register
//   holds a result the sink has not taken.
// Reset (arst_n low, asynchronous): idle phase, counters and frames cleared,
//   output empty, timeout 8192, retry delay 1000, read code 0.
// ----------------------------------------------------------------------------
// clocked_serial_frame_exchange_core
// Slave end of a partner-clocked four-byte serial frame link, one pin sample
// per transaction, one status/result word per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clocked_serial_frame_exchange_core_macros.svh"

module clocked_serial_frame_exchange_core (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// input ticks
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [1:0] command, [9:2] code_in, [17:10] extra_in, [33:18] value_in,
	// [34] serial_clock, [35] serial_data_in, [39:36] zero
	input  wire logic [39:0] s_axis_tdata,

	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] serial_data_out, [1] select_out, [2] request_out, [3] busy_res,
	// [4] done_res, [12:5] code_out, [20:13] extra_out, [36:21] value_out,
	// [39:37] zero
	output logic [39:0]      m_axis_tdata,

	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	csfe_pkg::item_t item;
	csfe_pkg::cfg_t  cfg_q;
	csfe_pkg::res_t  res;
	csfe_pkg::res_t  out_q;
	logic            out_valid_q;
	logic            accept;

	// unpack the input transaction
	assign item.command        = s_axis_tdata[1:0];
	assign item.code_in        = s_axis_tdata[9:2];
	assign item.extra_in       = s_axis_tdata[17:10];
	assign item.value_in       = s_axis_tdata[33:18];
	assign item.serial_clock   = s_axis_tdata[34];
	assign item.serial_data_in = s_axis_tdata[35];

	// output register frees itself when the sink takes its word, so a new
	// tick can enter in the same cycle
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// configuration registers; index 3 has no register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks     <= csfe_pkg::TIMEOUT_RESET;
			cfg_q.retry_delay_ticks <= csfe_pkg::RETRY_DELAY_RESET;
			cfg_q.read_param_code   <= csfe_pkg::READ_CODE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				csfe_pkg::CFG_TIMEOUT:     cfg_q.timeout_ticks     <= cfg_data;
				csfe_pkg::CFG_RETRY_DELAY: cfg_q.retry_delay_ticks <= cfg_data;
				csfe_pkg::CFG_READ_CODE:   cfg_q.read_param_code   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// frame state machine; state advances only on an accepted tick
	csfe_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.item   (item),
		.cfg    (cfg_q),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_q.value_out, out_q.extra_out, out_q.code_out,
	                        out_q.done_res, out_q.busy_res, out_q.request_out,
	                        out_q.select_out, out_q.serial_data_out};

	// every accepted tick yields a result word in the next cycle
	`CSFE_ASSERT_NEXT(a_result_follows, accept, m_axis_tvalid, "accepted tick left no result")

	// completion ends the frame: not busy and lines released
	`CSFE_ASSERT_NOW(a_done_idle, m_axis_tvalid && out_q.done_res,
		!out_q.busy_res && !out_q.select_out, "done while frame still active")

	// select and request move together and only inside a busy period
	`CSFE_ASSERT_NOW(a_lines_busy, m_axis_tvalid && out_q.select_out,
		out_q.request_out && out_q.busy_res, "select without request or busy")

endmodule

`default_nettype wire
